// ===== rtl/least_squares_line_fit_top_macros.svh =====
// assertion helpers for the checker file
`ifndef LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH

// consequent checked in the same cycle
`define LSLF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lslf check failed");

// consequent checked in the next cycle
`define LSLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lslf check failed");

`endif

// ===== rtl/lslf_pkg.sv =====
`timescale 1ns / 1ps
package lslf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IN_W        = 16;
    localparam int SX_W        = IN_W + CNT_W;
    localparam int SX2_W       = 2 * IN_W - 1 + CNT_W;
    localparam int SXY_W       = 2 * IN_W + CNT_W;

    localparam int OUT_W       = 32;
    localparam int R2_W        = 17;
    localparam int ST_W        = 2;

    localparam int OP_W        = 64;
    localparam int HALF_W      = OP_W / 2;
    localparam int WIDE_W      = 118;
    localparam int QW          = 35;
    localparam int DCNT_W      = 8;

    localparam logic [DCNT_W-1:0] STEPS_FRAC16 = DCNT_W'(WIDE_W + 17);
    localparam logic [DCNT_W-1:0] STEPS_FRAC8  = DCNT_W'(WIDE_W + 9);
    localparam logic [2:0]        MUL_LAST     = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_XCONST = 2'd1;
    localparam logic [ST_W-1:0] ST_YCONST = 2'd2;
    localparam logic [ST_W-1:0] ST_OVER   = 2'd3;

    typedef enum logic [3:0] {
        P_NSX2, P_SXSX, P_NSY2, P_SYSY, P_NSXY, P_SXSY, P_SYSX2, P_SXSXY, P_MM, P_DD
    } t_prod;

    typedef enum logic [1:0] {
        D_SLOPE, D_ICPT, D_R2
    } t_dsel;

    typedef struct packed {
        logic       acc_en;
        logic       fit_start;
        logic       clear;
        logic       mul_en;
        logic [2:0] mul_step;
        t_prod      prod;
        logic       commit;
        logic       div_start;
        logic       div_store;
        t_dsel      dsel;
    } t_cmd;

    typedef struct packed {
        logic dxx_bad;
        logic dyy_bad;
        logic div_busy;
    } t_stat;

endpackage

// ===== rtl/lslf_ctrl.sv =====
`timescale 1ns / 1ps
module lslf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_last,
    input  lslf_pkg::t_stat i_stat,
    output logic           busy,
    output logic           o_valid,
    output lslf_pkg::t_cmd o_cmd
);
    import lslf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_COMMIT = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_DSTORE = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    t_prod      r_prod, n_prod;
    t_dsel      r_dsel, n_dsel;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_prod  = r_prod;
        n_dsel  = r_dsel;
        o_cmd          = '0;
        o_cmd.prod     = r_prod;
        o_cmd.dsel     = r_dsel;
        o_cmd.mul_step = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.acc_en = 1'b1;
                    if (i_last) begin
                        o_cmd.fit_start = 1'b1;
                        n_prod  = P_NSX2;
                        n_step  = 3'd0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == MUL_LAST) begin
                    n_state = S_COMMIT;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_step = 3'd0;
                case (r_prod)
                    P_SXSXY: begin
                        n_dsel  = D_SLOPE;
                        n_state = S_CHECK;
                    end
                    // divider starts once the product is in its register
                    P_DD: begin
                        n_dsel  = D_R2;
                        n_state = S_CHECK;
                    end
                    default: begin
                        n_prod  = t_prod'(4'(r_prod) + 4'd1);
                        n_state = S_MUL;
                    end
                endcase
            end
            S_CHECK: begin
                if (i_stat.dxx_bad) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.div_store = 1'b1;
                case (r_dsel)
                    D_SLOPE: begin
                        n_dsel  = D_ICPT;
                        n_state = S_CHECK;
                    end
                    D_ICPT: begin
                        if (i_stat.dyy_bad) begin
                            n_state = S_OUT;
                        end else begin
                            n_prod  = P_MM;
                            n_step  = 3'd0;
                            n_state = S_MUL;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                o_cmd.clear = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_prod  <= P_NSX2;
            r_dsel  <= D_SLOPE;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_prod  <= n_prod;
            r_dsel  <= n_dsel;
        end
    end

endmodule

// ===== rtl/lslf_dp.sv =====
`timescale 1ns / 1ps
module lslf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [lslf_pkg::IN_W-1:0]    i_x_value,
    input  logic signed [lslf_pkg::IN_W-1:0]    i_y_value,
    input  lslf_pkg::t_cmd                      i_cmd,
    output lslf_pkg::t_stat                     o_stat,
    output logic signed [lslf_pkg::OUT_W-1:0]   o_slope,
    output logic signed [lslf_pkg::OUT_W-1:0]   o_intercept,
    output logic        [lslf_pkg::R2_W-1:0]    o_r_squared,
    output logic        [lslf_pkg::ST_W-1:0]    o_status
);
    import lslf_pkg::*;

    localparam logic [QW-1:0]   POS_MAX = QW'(33'h0_7FFF_FFFF);
    localparam logic [QW-1:0]   NEG_MAX = QW'(33'h0_8000_0000);
    localparam logic [QW-1:0]   R2_ONE  = QW'(17'h1_0000);

    function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic [QW-1:0] m);
        logic [QW-1:0] lim;
        if (!neg) begin
            lim = (m > POS_MAX) ? POS_MAX : m;
            return lim[OUT_W-1:0];
        end
        lim = (m > NEG_MAX) ? NEG_MAX : m;
        return -lim[OUT_W-1:0];
    endfunction

    // running sums
    logic        [CNT_W-1:0]  r_cnt;
    logic signed [SX_W-1:0]   r_sx, r_sy;
    logic signed [SX2_W-1:0]  r_sx2, r_sy2;
    logic signed [SXY_W-1:0]  r_sxy;
    logic                     r_ovf;
    logic signed [2*IN_W-1:0] xx, yy, xy;

    assign xx = i_x_value * i_x_value;
    assign yy = i_y_value * i_y_value;
    assign xy = i_x_value * i_y_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sx2 <= '0;
            r_sy2 <= '0;
            r_sxy <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (r_cnt < CNT_W'(MAX_SAMPLES)) begin
                r_cnt <= r_cnt + 1'b1;
                r_sx  <= r_sx + SX_W'(i_x_value);
                r_sy  <= r_sy + SX_W'(i_y_value);
                r_sx2 <= r_sx2 + SX2_W'(xx);
                r_sy2 <= r_sy2 + SX2_W'(yy);
                r_sxy <= r_sxy + SXY_W'(xy);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // shared multiplier: four 32x32 partial products accumulated in turn
    logic signed [OP_W-1:0]   op_a, op_b;
    logic        [OP_W-1:0]   r_ma, r_mb;
    logic                     r_neg;
    logic        [OP_W-1:0]   r_pp;
    logic        [1:0]        r_pp_sh;
    logic        [WIDE_W-1:0] r_acc;
    logic        [2:0]        km1;
    logic        [HALF_W-1:0] pa, pb;
    logic        [2*OP_W-1:0] pp_ext;
    logic signed [WIDE_W-1:0] prod_val;
    logic signed [WIDE_W-1:0] r_dxx, r_dyy, r_dxy, r_bn, r_m2, r_dd;

    always_comb begin
        case (i_cmd.prod)
            P_NSX2:  begin op_a = OP_W'(r_cnt); op_b = OP_W'(r_sx2); end
            P_SXSX:  begin op_a = OP_W'(r_sx);  op_b = OP_W'(r_sx);  end
            P_NSY2:  begin op_a = OP_W'(r_cnt); op_b = OP_W'(r_sy2); end
            P_SYSY:  begin op_a = OP_W'(r_sy);  op_b = OP_W'(r_sy);  end
            P_NSXY:  begin op_a = OP_W'(r_cnt); op_b = OP_W'(r_sxy); end
            P_SXSY:  begin op_a = OP_W'(r_sx);  op_b = OP_W'(r_sy);  end
            P_SYSX2: begin op_a = OP_W'(r_sy);  op_b = OP_W'(r_sx2); end
            P_SXSXY: begin op_a = OP_W'(r_sx);  op_b = OP_W'(r_sxy); end
            P_MM:    begin op_a = OP_W'(r_dxy); op_b = OP_W'(r_dxy); end
            P_DD:    begin op_a = OP_W'(r_dxx); op_b = OP_W'(r_dyy); end
            default: begin op_a = '0;           op_b = '0;           end
        endcase
    end

    assign km1      = i_cmd.mul_step - 3'd1;
    assign pa       = km1[0] ? r_ma[OP_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign pb       = km1[1] ? r_mb[OP_W-1:HALF_W] : r_mb[HALF_W-1:0];
    assign pp_ext   = {{OP_W{1'b0}}, r_pp} << {r_pp_sh, 5'b0};
    assign prod_val = r_neg ? -$signed(r_acc) : $signed(r_acc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_step == 3'd0) begin
                r_ma  <= op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
                r_mb  <= op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);
                r_neg <= op_a[OP_W-1] ^ op_b[OP_W-1];
            end
            if (i_cmd.mul_step >= 3'd1 && i_cmd.mul_step <= 3'd4) begin
                r_pp    <= pa * pb;
                r_pp_sh <= 2'(km1[0]) + 2'(km1[1]);
            end
            if (i_cmd.mul_step >= 3'd2) begin
                r_acc <= ((i_cmd.mul_step == 3'd2) ? '0 : r_acc) + pp_ext[WIDE_W-1:0];
            end
        end
        if (i_cmd.commit) begin
            case (i_cmd.prod)
                P_NSX2:  r_dxx <= prod_val;
                P_SXSX:  r_dxx <= r_dxx - prod_val;
                P_NSY2:  r_dyy <= prod_val;
                P_SYSY:  r_dyy <= r_dyy - prod_val;
                P_NSXY:  r_dxy <= prod_val;
                P_SXSY:  r_dxy <= r_dxy - prod_val;
                P_SYSX2: r_bn  <= prod_val;
                P_SXSXY: r_bn  <= r_bn - prod_val;
                P_MM:    r_m2  <= prod_val;
                P_DD:    r_dd  <= prod_val;
                default: r_dd  <= r_dd;
            endcase
        end
    end

    logic dxx_bad, dyy_bad;
    assign dxx_bad = r_dxx[WIDE_W-1] || (r_dxx == '0);
    assign dyy_bad = r_dyy[WIDE_W-1] || (r_dyy == '0);

    // restoring divider, one quotient bit per cycle
    logic [WIDE_W-1:0] r_num, r_den, r_rem;
    logic [WIDE_W:0]   rem_sh, rem_diff;
    logic              ge;
    logic [QW-1:0]     r_q;
    logic              r_qsat;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_dbusy;
    logic [QW:0]       q_inc;
    logic [QW-1:0]     rmag;

    assign rem_sh   = {r_rem, r_num[WIDE_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign ge       = (rem_sh >= {1'b0, r_den});
    assign q_inc    = {1'b0, r_q} + 1'b1;
    assign rmag     = r_qsat ? '1 : q_inc[QW:1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_qsat <= 1'b0;
            case (i_cmd.dsel)
                D_SLOPE: begin
                    r_num  <= r_dxy[WIDE_W-1] ? WIDE_W'(-r_dxy) : WIDE_W'(r_dxy);
                    r_den  <= r_dxx;
                    r_dcnt <= STEPS_FRAC16;
                end
                D_ICPT: begin
                    r_num  <= r_bn[WIDE_W-1] ? WIDE_W'(-r_bn) : WIDE_W'(r_bn);
                    r_den  <= r_dxx;
                    r_dcnt <= STEPS_FRAC8;
                end
                default: begin
                    r_num  <= r_m2;
                    r_den  <= r_dd;
                    r_dcnt <= STEPS_FRAC16;
                end
            endcase
        end else if (r_dbusy) begin
            r_rem  <= ge ? rem_diff[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
            r_num  <= r_num << 1;
            r_qsat <= r_qsat | r_q[QW-1];
            r_q    <= {r_q[QW-2:0], ge};
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && r_dcnt == DCNT_W'(1)) begin
            r_dbusy <= 1'b0;
        end
    end

    // result registers
    logic [OUT_W-1:0] r_slope, r_icpt;
    logic [R2_W-1:0]  r_r2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fit_start) begin
            r_slope <= '0;
            r_icpt  <= '0;
            r_r2    <= '0;
        end else if (i_cmd.div_store) begin
            case (i_cmd.dsel)
                D_SLOPE: r_slope <= sat32(r_dxy[WIDE_W-1], rmag);
                D_ICPT:  r_icpt  <= sat32(r_bn[WIDE_W-1], rmag);
                default: r_r2    <= (rmag > R2_ONE) ? R2_W'(R2_ONE) : rmag[R2_W-1:0];
            endcase
        end
    end

    always_comb begin
        if (dxx_bad) begin
            o_status = ST_XCONST;
        end else if (r_ovf) begin
            o_status = ST_OVER;
        end else if (dyy_bad) begin
            o_status = ST_YCONST;
        end else begin
            o_status = ST_OK;
        end
    end

    assign o_slope          = r_slope;
    assign o_intercept      = r_icpt;
    assign o_r_squared      = r_r2;
    assign o_stat.dxx_bad   = dxx_bad;
    assign o_stat.dyy_bad   = dyy_bad;
    assign o_stat.div_busy  = r_dbusy;

endmodule

// ===== rtl/least_squares_line_fit_top.sv =====
`timescale 1ns / 1ps
// least-squares straight-line fit over a set of signed Q8.8 (x, y) samples
// request: raise start with i_x_value, i_y_value and i_last; it is taken at
// a clock edge where busy is low. a request without i_last only adds the pair
// to the running sums and busy stays low, so one pair per cycle is taken.
// a request with i_last adds its pair and starts the fit; busy stays high until
// the result has been shown. the fit runs ten 64x64 products on one 32x32
// multiplier and three divisions on one bit-serial divider (135 or 127
// quotient bits). constant y skips the r squared part; constant x skips all
// divisions. the next request is taken in the cycle after the result.
// the result appears for exactly one cycle with o_valid high: o_slope and
// o_intercept in Q16.16, o_r_squared in Q1.16, o_status. the receiver cannot
// stall and must take it in that cycle. the sums clear after the result.
// reset (i_rst_n low, synchronous) clears the sums and returns to idle.
module least_squares_line_fit_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic signed [lslf_pkg::IN_W-1:0]    i_x_value,
    input  logic signed [lslf_pkg::IN_W-1:0]    i_y_value,
    input  logic                                i_last,
    output logic                                busy,
    output logic                                o_valid,
    output logic signed [lslf_pkg::OUT_W-1:0]   o_slope,
    output logic signed [lslf_pkg::OUT_W-1:0]   o_intercept,
    output logic        [lslf_pkg::R2_W-1:0]    o_r_squared,
    output logic        [lslf_pkg::ST_W-1:0]    o_status
);
    import lslf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lslf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .i_stat  (stat),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    lslf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_slope     (o_slope),
        .o_intercept (o_intercept),
        .o_r_squared (o_r_squared),
        .o_status    (o_status)
    );

endmodule

// ===== rtl/lslf_checker.sv =====
`timescale 1ns / 1ps
`include "least_squares_line_fit_top_macros.svh"
module lslf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                i_last,
    input logic                                busy,
    input logic                                o_valid,
    input logic signed [lslf_pkg::OUT_W-1:0]   o_slope,
    input logic signed [lslf_pkg::OUT_W-1:0]   o_intercept,
    input logic        [lslf_pkg::R2_W-1:0]    o_r_squared,
    input logic        [lslf_pkg::ST_W-1:0]    o_status
);
    import lslf_pkg::*;

    // a plain sample never stalls the next one
    `LSLF_ASSERT_NEXT(a_no_stall, i_clk, i_rst_n, start && !busy && !i_last, !busy)
    // the last sample starts a fit
    `LSLF_ASSERT_NEXT(a_fit_busy, i_clk, i_rst_n, start && !busy && i_last, busy && !o_valid)
    // result strobe lasts one cycle and ends the fit
    `LSLF_ASSERT_NEXT(a_one_strobe, i_clk, i_rst_n, o_valid, !o_valid && !busy)
    // no fit means all-zero fields, and r squared never exceeds one
    `LSLF_ASSERT_SAME(a_fields, i_clk, i_rst_n, o_valid, (o_r_squared <= 17'h1_0000) && (o_status != ST_XCONST || (o_slope == '0 && o_intercept == '0 && o_r_squared == '0)))

endmodule

bind least_squares_line_fit_top lslf_checker u_lslf_checker (.*);
